// File: rtl/ndm_pkg.sv
// Shared types, constants and the fraction weight table for the degree-minute parser.
`timescale 1ns / 1ps

package ndm_pkg;

	// Character codes
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_W    = 8'h57;
	localparam logic [7:0] CHAR_S    = 8'h53;

	// Field and accumulator widths
	localparam int CHAR_W_BITS = 8;
	localparam int INT_W       = 32;
	localparam int FRAC_W      = 24;
	localparam int CNT_W       = 3;
	localparam int WEIGHT_W    = 20;
	localparam int DEG_W       = 16;
	localparam int BILL_W      = 31;
	localparam int QUOT_W      = 26;
	localparam int MIN_W       = 7;

	localparam logic [CNT_W-1:0] MAX_FRAC_DIGITS = 3'd7;

	// Reciprocal constants for exact unsigned 32-bit division
	localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
	localparam int          DIV100_SHIFT = 37;
	localparam logic [31:0] DIV3_MAGIC   = 32'hAAAAAAAB;
	localparam int          DIV3_SHIFT   = 33;
	localparam logic [6:0]  HUNDRED      = 7'd100;

	// Five times ten million: minutes scale folded with the times-five step
	localparam logic [25:0] MIN_SCALE_X5 = 26'd50000000;

	typedef enum logic [1:0] {
		PH_INT,
		PH_FRAC,
		PH_DONE
	} phase_t;

	// Finished term handed from the parser to the conversion pipeline
	typedef struct packed {
		logic [INT_W-1:0]  int_val;
		logic [FRAC_W-1:0] frac;
		logic              neg;
	} ndm_term_t;

	// Weight of a fraction digit in ten-millionths of a minute
	function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [CNT_W-1:0] idx);
		logic [WEIGHT_W-1:0] w;
		unique case (idx)
			3'd0: w = 20'd1000000;
			3'd1: w = 20'd100000;
			3'd2: w = 20'd10000;
			3'd3: w = 20'd1000;
			3'd4: w = 20'd100;
			3'd5: w = 20'd10;
			3'd6: w = 20'd1;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// File: rtl/ndm_parse.sv
// Character parser: accumulates integer and fraction digits and emits a finished term.
`timescale 1ns / 1ps

module ndm_parse
	import ndm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [CHAR_W_BITS-1:0] char_in,
	input  logic                   is_last,
	input  logic [CHAR_W_BITS-1:0] hemisphere,
	output logic                   term_valid,
	output ndm_term_t              term
);

	phase_t              phase_q, phase_d;
	logic [INT_W-1:0]    int_q, int_d;
	logic [FRAC_W-1:0]   frac_q, frac_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                is_digit;
	logic [3:0]          digit;

	assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
	assign digit    = char_in[3:0];

	// Next state of the parse after this character
	always_comb begin
		phase_d = phase_q;
		int_d   = int_q;
		frac_d  = frac_q;
		cnt_d   = cnt_q;
		unique case (phase_q)
			PH_INT: begin
				if (is_digit) begin
					int_d = (int_q << 3) + (int_q << 1) + INT_W'(digit);
				end else if (char_in == CHAR_DOT) begin
					phase_d = PH_FRAC;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_FRAC: begin
				if (is_digit) begin
					if (cnt_q < MAX_FRAC_DIGITS) begin
						frac_d = frac_q + FRAC_W'(digit) * FRAC_W'(frac_weight(cnt_q));
						cnt_d  = cnt_q + 3'd1;
					end
				end else begin
					phase_d = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	// Hand the finished term downstream on the last character
	assign term_valid   = accept && is_last;
	assign term.int_val = int_d;
	assign term.frac    = frac_d;
	assign term.neg     = (hemisphere == CHAR_W) || (hemisphere == CHAR_S);

	// Advance state; return to the start after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INT;
			int_q   <= '0;
			frac_q  <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			if (is_last) begin
				phase_q <= PH_INT;
				int_q   <= '0;
				frac_q  <= '0;
				cnt_q   <= '0;
			end else begin
				phase_q <= phase_d;
				int_q   <= int_d;
				frac_q  <= frac_d;
				cnt_q   <= cnt_d;
			end
		end
	end

	a_int_phase_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_INT) |-> (frac_q == '0) && (cnt_q == '0))
		else $error("fraction state set during integer digits");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frac_q < FRAC_W'(10000000))
		else $error("fraction accumulator out of range");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_last) |=> (phase_q == PH_INT) && (int_q == '0))
		else $error("parser not cleared after last character");

endmodule

// File: rtl/ndm_convert.sv
// Conversion pipeline: splits degrees and minutes and scales to billionths of a degree.
`timescale 1ns / 1ps

module ndm_convert
	import ndm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ndm_term_t         in_term,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DEG_W-1:0]  degrees,
	output logic [BILL_W-1:0] billionths,
	output logic              is_negative
);

	// Stage valids
	logic v1_s1, v2_s2, v3_s3, v4_s4, vo_q;
	logic rdy1, rdy2, rdy3, rdy4, rdyo;

	// Stage payloads
	ndm_term_t            term_s1;
	logic [QUOT_W-1:0]    quot_s2;
	logic [INT_W-1:0]     int_s2;
	logic [FRAC_W-1:0]    frac_s2, frac_s3;
	logic                 neg_s2, neg_s3, neg_s4;
	logic [DEG_W-1:0]     deg_s3, deg_s4;
	logic [MIN_W-1:0]     min_s3;
	logic [31:0]          scaled_s4;
	logic [DEG_W-1:0]     deg_q;
	logic [BILL_W-1:0]    bill_q;
	logic                 neg_q;

	logic [63:0]          prod100;
	logic [32:0]          back100;
	logic [31:0]          scaled_d;
	logic [63:0]          prod3;

	// A stage loads when it is empty or its content moves on
	assign rdyo     = !vo_q || out_ready;
	assign rdy4     = !v4_s4 || rdyo;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_ready = rdy1;

	// Datapath between stages
	assign prod100  = term_s1.int_val * DIV100_MAGIC;
	assign back100  = quot_s2 * HUNDRED;
	assign scaled_d = 32'(min_s3) * 32'(MIN_SCALE_X5) + (32'(frac_s3) << 2)
		+ 32'(frac_s3) + 32'd1;
	assign prod3    = scaled_s4 * DIV3_MAGIC;

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			vo_q  <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
			if (rdyo) vo_q  <= v4_s4;
		end
	end

	// Pipeline payloads
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			term_s1 <= in_term;
		end
		if (rdy2 && v1_s1) begin
			quot_s2 <= prod100[DIV100_SHIFT +: QUOT_W];
			int_s2  <= term_s1.int_val;
			frac_s2 <= term_s1.frac;
			neg_s2  <= term_s1.neg;
		end
		if (rdy3 && v2_s2) begin
			deg_s3  <= quot_s2[DEG_W-1:0];
			min_s3  <= int_s2[MIN_W-1:0] - back100[MIN_W-1:0];
			frac_s3 <= frac_s2;
			neg_s3  <= neg_s2;
		end
		if (rdy4 && v3_s3) begin
			deg_s4    <= deg_s3;
			scaled_s4 <= scaled_d;
			neg_s4    <= neg_s3;
		end
		if (rdyo && v4_s4) begin
			deg_q  <= deg_s4;
			bill_q <= prod3[DIV3_SHIFT +: BILL_W];
			neg_q  <= neg_s4;
		end
	end

	assign out_valid   = vo_q;
	assign degrees     = deg_q;
	assign billionths  = bill_q;
	assign is_negative = neg_q;

	a_quot_exact: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 |-> (back100 <= {1'b0, int_s2}) && (({1'b0, int_s2} - back100) < 33'd100))
		else $error("divide by 100 quotient off");

	a_minutes_range: assert property (@(posedge clk) disable iff (!arst_n)
		v3_s3 |-> (min_s3 < HUNDRED))
		else $error("minutes out of range");

	a_bill_range: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q |-> (bill_q <= 31'd1431655765))
		else $error("billionths beyond quotient range");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v1_s1)
		else $error("accepted term lost at first stage");

endmodule

// File: rtl/nmea_degree_minute_parser.sv
// Top level: NMEA degree-minute term parser with stream ports.
// Path: a term passes registers s1, s2, s3, s4 and then the output register.
// Throughput: one character per cycle; the five-register conversion pipeline
//   holds up to five finished terms, so input stalls only when all are held.
// Reset: arst_n clears the parse state and all pipeline valids; no clearing pass.
`timescale 1ns / 1ps

module nmea_degree_minute_parser
	import ndm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] char_in, [15:8] hemisphere
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [15:0] degrees, [46:16] billionths, [47] is_negative
);

	logic              accept;
	logic              term_valid;
	ndm_term_t         term;
	logic [DEG_W-1:0]  degrees;
	logic [BILL_W-1:0] billionths;
	logic              is_negative;

	assign accept = s_tvalid && s_tready;

	ndm_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_in    (s_tdata[7:0]),
		.is_last    (s_tlast),
		.hemisphere (s_tdata[15:8]),
		.term_valid (term_valid),
		.term       (term)
	);

	ndm_convert u_convert (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (term_valid),
		.in_ready    (s_tready),
		.in_term     (term),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.degrees     (degrees),
		.billionths  (billionths),
		.is_negative (is_negative)
	);

	assign m_tdata = {is_negative, billionths, degrees};

endmodule
